[sv/ps2_scancode_event_decoder_defines.svh]
// Assertion macros shared by the scan code decoder RTL.
`ifndef PS2_SCANCODE_EVENT_DECODER_DEFINES_SVH
`define PS2_SCANCODE_EVENT_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define PS2SD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("ps2sd assertion failed");

// Expression must never be true outside reset.
`define PS2SD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ps2sd forbidden condition seen");

`else

`define PS2SD_ASSERT(lbl, clk, rst_n, prop)
`define PS2SD_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[sv/ps2sd_pkg.sv]
// Types, constants and helpers for the PS/2 set 1 scan code event decoder.
package ps2sd_pkg;

    localparam int RING_DEPTH = 256;
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);

    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_RESEND = 8'hFE;
    localparam logic [7:0] BYTE_NULL   = 8'h00;
    localparam logic [7:0] BYTE_EXT    = 8'hE0;
    localparam logic [7:0] BYTE_PAUSE  = 8'hE1;

    localparam logic [6:0] KEY_LSHIFT = 7'h2A;
    localparam logic [6:0] KEY_RSHIFT = 7'h36;
    localparam logic [6:0] KEY_CTRL   = 7'h1D;
    localparam logic [6:0] KEY_ALT    = 7'h38;
    localparam logic [6:0] KEY_CAPS   = 7'h3A;
    localparam logic [6:0] KEY_NUM    = 7'h45;
    localparam logic [6:0] KEY_SCROLL = 7'h46;

    localparam int MBIT_SHIFT  = 0;
    localparam int MBIT_CTRL   = 1;
    localparam int MBIT_ALT    = 2;
    localparam int MBIT_CAPS   = 3;
    localparam int MBIT_NUM    = 4;
    localparam int MBIT_SCROLL = 5;

    localparam logic [2:0] PAUSE_IDLE = 3'd0;
    localparam logic [2:0] PAUSE_LAST = 3'd5;

    typedef enum logic [1:0] {
        ACT_MAKE   = 2'd0,
        ACT_BREAK  = 2'd1,
        ACT_REPEAT = 2'd2,
        ACT_ERROR  = 2'd3
    } action_t;

    typedef struct packed {
        logic             ext_pending;
        logic [2:0]       pause_pos;
        logic [5:0]       mods;
        logic [CNT_W-1:0] count;
    } parse_state_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] event_code;
        action_t    action;
        logic [5:0] modifiers;
        logic       extended;
        logic       synthetic;
        logic       parser_error;
        logic       overflow_drop;
    } key_event_t;

    typedef struct packed {
        logic we;
        logic value;
    } map_write_t;

    // Expected byte of the pause tail at positions 1..5.
    function automatic logic [7:0] pause_tail(input logic [2:0] pos);
        logic [7:0] b;
        case (pos)
            3'd1:    b = 8'h1D;
            3'd2:    b = 8'h45;
            3'd3:    b = 8'hE1;
            3'd4:    b = 8'h9D;
            3'd5:    b = 8'hC5;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

[sv/ps2sd_step.sv]
// Per-byte parser step: next parser state, key map update and event.
module ps2sd_step (
    input  logic [7:0]             scan_byte,
    input  ps2sd_pkg::parse_state_t st,
    input  logic                   held,
    output ps2sd_pkg::parse_state_t st_next,
    output ps2sd_pkg::map_write_t  map_wr,
    output ps2sd_pkg::key_event_t  evt
);

    logic       ignore;
    logic       emit;
    logic [7:0] e_code;
    ps2sd_pkg::action_t e_act;
    logic       e_ext;
    logic       e_synth;
    logic       e_err;
    logic [5:0] mods;
    logic       over;

    assign ignore = (scan_byte == ps2sd_pkg::BYTE_ACK)
                 || (scan_byte == ps2sd_pkg::BYTE_RESEND)
                 || (scan_byte == ps2sd_pkg::BYTE_NULL);

    always_comb
    begin
        st_next      = st;
        map_wr.we    = 1'b0;
        map_wr.value = 1'b0;
        emit         = 1'b0;
        e_code       = scan_byte;
        e_act        = ps2sd_pkg::ACT_ERROR;
        e_ext        = 1'b0;
        e_synth      = 1'b0;
        e_err        = 1'b0;

        if (!ignore)
        begin
            if (st.pause_pos != ps2sd_pkg::PAUSE_IDLE)
            begin
                if (st.pause_pos > ps2sd_pkg::PAUSE_LAST
                    || scan_byte != ps2sd_pkg::pause_tail(st.pause_pos))
                begin
                    st_next.ext_pending = 1'b0;
                    st_next.pause_pos   = ps2sd_pkg::PAUSE_IDLE;
                    emit                = 1'b1;
                    e_err               = 1'b1;
                end
                else if (st.pause_pos == ps2sd_pkg::PAUSE_LAST)
                begin
                    st_next.pause_pos = ps2sd_pkg::PAUSE_IDLE;
                    emit              = 1'b1;
                    e_code            = {1'b0, ps2sd_pkg::KEY_NUM};
                    e_act             = ps2sd_pkg::ACT_MAKE;
                    e_synth           = 1'b1;
                end
                else
                begin
                    st_next.pause_pos = st.pause_pos + 3'd1;
                end
            end
            else if (scan_byte == ps2sd_pkg::BYTE_PAUSE)
            begin
                st_next.pause_pos   = 3'd1;
                st_next.ext_pending = 1'b0;
            end
            else if (scan_byte == ps2sd_pkg::BYTE_EXT)
            begin
                if (st.ext_pending)
                begin
                    st_next.ext_pending = 1'b0;
                    emit                = 1'b1;
                    e_err               = 1'b1;
                end
                else
                begin
                    st_next.ext_pending = 1'b1;
                end
            end
            else
            begin
                st_next.ext_pending = 1'b0;
                emit                = 1'b1;
                e_code              = {1'b0, scan_byte[6:0]};
                e_ext               = st.ext_pending;
                map_wr.we           = scan_byte[7] || !held;
                map_wr.value        = !scan_byte[7];
                if (scan_byte[7])
                    e_act = ps2sd_pkg::ACT_BREAK;
                else if (held)
                    e_act = ps2sd_pkg::ACT_REPEAT;
                else
                    e_act = ps2sd_pkg::ACT_MAKE;
            end
        end

        // modifier tracking, make and break only
        mods = st.mods;
        if (emit && (e_act == ps2sd_pkg::ACT_MAKE || e_act == ps2sd_pkg::ACT_BREAK))
        begin
            case (e_code[6:0])
                ps2sd_pkg::KEY_LSHIFT,
                ps2sd_pkg::KEY_RSHIFT: mods[ps2sd_pkg::MBIT_SHIFT] =
                                           (e_act == ps2sd_pkg::ACT_MAKE);
                ps2sd_pkg::KEY_CTRL:   mods[ps2sd_pkg::MBIT_CTRL] =
                                           (e_act == ps2sd_pkg::ACT_MAKE);
                ps2sd_pkg::KEY_ALT:    mods[ps2sd_pkg::MBIT_ALT] =
                                           (e_act == ps2sd_pkg::ACT_MAKE);
                ps2sd_pkg::KEY_CAPS:
                    if (e_act == ps2sd_pkg::ACT_MAKE && !e_ext)
                        mods[ps2sd_pkg::MBIT_CAPS] = !mods[ps2sd_pkg::MBIT_CAPS];
                ps2sd_pkg::KEY_NUM:
                    if (e_act == ps2sd_pkg::ACT_MAKE && !e_synth)
                        mods[ps2sd_pkg::MBIT_NUM] = !mods[ps2sd_pkg::MBIT_NUM];
                ps2sd_pkg::KEY_SCROLL:
                    if (e_act == ps2sd_pkg::ACT_MAKE && !e_ext)
                        mods[ps2sd_pkg::MBIT_SCROLL] = !mods[ps2sd_pkg::MBIT_SCROLL];
                default: mods = st.mods;
            endcase
        end
        st_next.mods = mods;

        over = (st.count >= ps2sd_pkg::CNT_W'(ps2sd_pkg::RING_DEPTH));
        if (emit && !over)
            st_next.count = st.count + ps2sd_pkg::CNT_W'(1);

        evt.valid         = emit;
        evt.event_code    = e_code;
        evt.action        = e_act;
        evt.modifiers     = mods;
        evt.extended      = e_ext;
        evt.synthetic     = e_synth;
        evt.parser_error  = e_err;
        evt.overflow_drop = over;
    end

endmodule

[sv/ps2_scancode_event_decoder.sv]
// Top level of the PS/2 set 1 scan code event decoder.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+------------------------------------------
//   in      | input     | in_valid / in_ready | scan_byte
//   out     | output    | out_valid/out_ready | event_code action modifiers extended
//           |           |                     | synthetic parser_error overflow_drop
//
// One byte per cycle while the output is not stalled: input register, combinational parse logic, result register.
// A byte that makes an event passes the input register and then the result register before it shows up on out_valid.
// The parser and key-down map update when the byte leaves the input register,
// which happens whenever the result register is empty or being drained.
// A stalled output holds both stages; in_ready drops only while both are full.
// Reset clears the parser, modifiers, event count and all 256 key-down bits at once.
`include "ps2_scancode_event_decoder_defines.svh"

module ps2_scancode_event_decoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] scan_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] event_code,
    output logic [1:0] action,
    output logic [5:0] modifiers,
    output logic       extended,
    output logic       synthetic,
    output logic       parser_error,
    output logic       overflow_drop
);

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    logic [7:0]              s1_byte_reg;
    ps2sd_pkg::parse_state_t st_reg;
    ps2sd_pkg::parse_state_t st_next;
    logic [255:0]            key_down_reg;
    logic [7:0]              map_idx;
    logic                    held;
    ps2sd_pkg::map_write_t   map_wr;
    ps2sd_pkg::key_event_t   evt;
    ps2sd_pkg::key_event_t   out_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_free;
    logic                    adv;

    assign out_free = !out_valid_reg || out_ready;
    assign adv      = s1_valid_reg && out_free;
    assign in_ready = !s1_valid_reg || out_free;

    // extended keys live in the upper half of the map
    assign map_idx = {st_reg.ext_pending, s1_byte_reg[6:0]};
    assign held    = key_down_reg[map_idx];

    ps2sd_step u_step (
        .scan_byte (s1_byte_reg),
        .st        (st_reg),
        .held      (held),
        .st_next   (st_next),
        .map_wr    (map_wr),
        .evt       (evt)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = in_valid;
        out_valid_next = out_valid_reg;
        if (out_free)
            out_valid_next = adv && evt.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            st_reg        <= '0;
            key_down_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                st_reg <= st_next;
                if (map_wr.we)
                    key_down_reg[map_idx] <= map_wr.value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            s1_byte_reg <= scan_byte;
        if (adv && evt.valid)
            out_reg <= evt;
    end

    assign out_valid     = out_valid_reg;
    assign event_code    = out_reg.event_code;
    assign action        = out_reg.action;
    assign modifiers     = out_reg.modifiers;
    assign extended      = out_reg.extended;
    assign synthetic     = out_reg.synthetic;
    assign parser_error  = out_reg.parser_error;
    assign overflow_drop = out_reg.overflow_drop;

    `PS2SD_ASSERT_NEVER(a_pause_range, clk, rst_n, st_reg.pause_pos > ps2sd_pkg::PAUSE_LAST)
    `PS2SD_ASSERT_NEVER(a_ext_in_pause, clk, rst_n,
        st_reg.ext_pending && st_reg.pause_pos != ps2sd_pkg::PAUSE_IDLE)
    `PS2SD_ASSERT(a_count_sat, clk, rst_n,
        st_reg.count <= ps2sd_pkg::CNT_W'(ps2sd_pkg::RING_DEPTH))
    `PS2SD_ASSERT(a_err_clean, clk, rst_n,
        out_valid_reg && out_reg.parser_error |->
            out_reg.action == ps2sd_pkg::ACT_ERROR && !out_reg.extended && !out_reg.synthetic)
    `PS2SD_ASSERT(a_make_sets_map, clk, rst_n,
        adv && evt.valid && !evt.synthetic && evt.action == ps2sd_pkg::ACT_MAKE
            |=> key_down_reg[$past(map_idx)])

endmodule
